// ----- design/melody_tone_sequencer_macros.svh -----
// Assertion macros for the melody tone sequencer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MELODY_TONE_SEQUENCER_MACROS_SVH
`define MELODY_TONE_SEQUENCER_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define MTS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mts_pkg.sv -----
// Shared types, constants and the duty table of the melody tone sequencer.
// No dependencies; imported by mts_seq_core and the top level.
package mts_pkg;

    localparam int STORE_DEPTH     = 256;  // power of two, 16 to 256
    localparam int ADDR_BITS       = $clog2(STORE_DEPTH);
    localparam int DIVIDER_BITS    = 15;   // 8 to 16
    localparam int WORD_BITS       = 6;
    localparam int BYTE_BITS       = 8;
    localparam int PTR_BITS        = 8;
    localparam int DUTY_BITS       = 5;
    localparam int STEP_BITS       = 5;
    localparam int STEP_TICK_BITS  = 7;
    localparam int REG_INDEX_BITS  = 1;
    localparam int REG_DATA_BITS   = 1;
    localparam int IN_TDATA_BITS   = 16;
    localparam int OUT_TDATA_BITS  = 16;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [REG_INDEX_BITS-1:0] REG_MELODY_PRESENT = 1'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_TONE_ENABLE    = 1'd1;

    localparam logic [3:0] CODE_STOP     = 4'd1;
    localparam logic [3:0] CODE_TONE_MIN = 4'd2;
    localparam logic [3:0] CODE_TONE_MAX = 4'd13;

    // Half-period lengths, indexed by {phase, tone code}.
    localparam logic [3:0] CYCLE_TABLE [64] = '{
        4'd0, 4'd0, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd13, 4'd14, 4'd14, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd11,
        4'd11, 4'd12, 4'd13, 4'd13, 4'd14, 4'd15, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd12, 4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11,
        4'd11, 4'd12, 4'd13, 4'd14, 4'd14, 4'd15, 4'd0, 4'd0
    };

    typedef struct packed {
        logic                 go;
        logic                 cmd;
        logic [BYTE_BITS-1:0] addr;
        logic [BYTE_BITS-1:0] data;
    } step_t;

    typedef struct packed {
        logic melody_present;
        logic tone_enable;
    } cfg_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic                tone_out;
        logic                one_second;
        logic                stop_flag;
        logic                word_invalid;
        logic [PTR_BITS-1:0] play_address;
    } result_t;

    typedef struct packed {
        logic fwd_active;
        logic tick_done;
    } core_status_t;

endpackage

// ----- design/mts_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/mts_seq_core.sv -----
// Divider, duty-cycle and step state of the melody tone sequencer.
// Depends on mts_pkg; drives the ports of the melody store RAM.
module mts_seq_core
    import mts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  step_t                step,
    input  cfg_t                 cfg,
    input  logic [WORD_BITS-1:0] ram_rdata,
    output logic [ADDR_BITS-1:0] ram_raddr,
    output ram_wr_t              ram_wr,
    output result_t              result,
    output core_status_t         status
);

    logic [DIVIDER_BITS-1:0] divider_reg, divider_next;
    logic [DUTY_BITS-1:0]    duty_count_reg, duty_count_next;
    logic [1:0]              duty_phase_reg, duty_phase_next;
    logic [STEP_BITS-1:0]    step_count_reg, step_count_next;
    logic [PTR_BITS-1:0]     pointer_reg, pointer_next;
    logic                    stopped_reg, stopped_next;
    logic                    tone_reg, tone_next;
    logic                    fwd_valid_reg, fwd_valid_next;
    logic [WORD_BITS-1:0]    fwd_data_reg;

    logic [WORD_BITS-1:0] word;
    logic [3:0]           code;
    logic [3:0]           half_len;
    logic [DUTY_BITS-1:0] limit;
    logic [DUTY_BITS-1:0] duty_inc;
    logic [STEP_BITS-1:0] step_inc;
    logic                 is_tick;
    logic                 is_write;
    logic                 second;

    // The read issued last cycle targets the current pointer; a write to
    // that entry in the same cycle is forwarded.
    assign word     = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign code     = word[3:0];
    assign is_tick  = step.go && (step.cmd == CMD_TICK);
    assign is_write = step.go && (step.cmd == CMD_WRITE);
    assign half_len = CYCLE_TABLE[{duty_phase_reg, code}];
    // Low octave (bit 4 clear) doubles the phase length.
    assign limit    = word[4] ? {1'b0, half_len} : {half_len, 1'b0};
    assign duty_inc = duty_count_reg + 1'b1;
    assign step_inc = step_count_reg + 1'b1;

    always_comb
    begin
        divider_next    = divider_reg;
        duty_count_next = duty_count_reg;
        duty_phase_next = duty_phase_reg;
        step_count_next = step_count_reg;
        pointer_next    = pointer_reg;
        stopped_next    = stopped_reg;
        tone_next       = tone_reg;
        second          = 1'b0;
        if (is_tick)
        begin
            divider_next = divider_reg + 1'b1;
            second       = (divider_next == '0);
            if (cfg.melody_present)
            begin
                tone_next = 1'b0;
                if ((code >= CODE_TONE_MIN) && (code <= CODE_TONE_MAX))
                begin
                    tone_next = duty_phase_reg[0] & cfg.tone_enable;
                    if (duty_inc >= limit)
                    begin
                        duty_count_next = '0;
                        duty_phase_next = duty_phase_reg + 1'b1;
                    end
                    else
                    begin
                        duty_count_next = duty_inc;
                    end
                end
                else if (code == CODE_STOP)
                begin
                    stopped_next = 1'b1;
                end
                if (divider_next[STEP_TICK_BITS-1:0] == '0)
                begin
                    // Bit 5 selects a 32-step note, else 16.
                    step_count_next = word[5] ? step_inc
                                              : {1'b0, step_inc[STEP_BITS-2:0]};
                    if (step_count_next == '0)
                    begin
                        pointer_next = pointer_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign ram_raddr   = pointer_next[ADDR_BITS-1:0];
    assign ram_wr.en   = is_write;
    assign ram_wr.addr = step.addr[ADDR_BITS-1:0];
    assign ram_wr.data = step.data[WORD_BITS-1:0];

    assign fwd_valid_next = is_write && (ram_wr.addr == ram_raddr);

    assign result.tone_out     = tone_next;
    assign result.one_second   = second;
    assign result.stop_flag    = stopped_next;
    assign result.word_invalid = is_write && ((step.data[7:6] != 2'b00)
                                              || (step.data[3:0] > CODE_TONE_MAX));
    assign result.play_address = pointer_next;

    assign status.fwd_active = fwd_valid_reg;
    assign status.tick_done  = is_tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg    <= '0;
            duty_count_reg <= '0;
            duty_phase_reg <= '0;
            step_count_reg <= '0;
            pointer_reg    <= '0;
            stopped_reg    <= 1'b0;
            tone_reg       <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            divider_reg    <= divider_next;
            duty_count_reg <= duty_count_next;
            duty_phase_reg <= duty_phase_next;
            step_count_reg <= step_count_next;
            pointer_reg    <= pointer_next;
            stopped_reg    <= stopped_next;
            tone_reg       <= tone_next;
            fwd_valid_reg  <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wr.data;
    end

endmodule

// ----- design/melody_tone_sequencer.sv -----
// Top level of the melody tone sequencer: stream handshake, config registers,
// input stage and output register. Depends on mts_pkg, mts_ram, mts_seq_core.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    s_tuser = command, s_tdata = address, data
//   m_*       out   m_tvalid/m_tready    m_tdata = tone, second, stop, invalid, address
//   cfg_*     in    cfg_we               cfg_index, cfg_data
//
// One item is taken per cycle while the output is not stalled; a result passes
// through the input stage, then the state update into the output register.
// The melody store RAM is read every cycle at the next play address, so a tick
// sees its word without waiting; a write to that entry is forwarded.
// A stall on m_tready holds the output register; one more item waits in the
// input stage before s_tready drops. Reset clears all control and sequencer state.
`include "melody_tone_sequencer_macros.svh"

module melody_tone_sequencer
    import mts_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [7:0] store_address, [15:8] store_data
    input  logic                      s_tuser,   // [0] command
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // [0] tone_out, [1] one_second,
                                                 // [2] stop_flag, [3] word_invalid,
                                                 // [11:4] play_address, rest zero
    input  logic                      cfg_we,
    input  logic [REG_INDEX_BITS-1:0] cfg_index,
    input  logic [REG_DATA_BITS-1:0]  cfg_data
);

    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic [BYTE_BITS-1:0] in_addr_reg;
    logic [BYTE_BITS-1:0] in_data_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;
    cfg_t                 cfg_reg;

    logic                 advance;
    step_t                step;
    result_t              result;
    core_status_t         status;
    ram_wr_t              ram_wr;
    logic [ADDR_BITS-1:0] ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    // Advance the input stage whenever the output register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign step.go   = advance;
    assign step.cmd  = in_cmd_reg;
    assign step.addr = in_addr_reg;
    assign step.data = in_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MELODY_PRESENT: cfg_reg.melody_present <= cfg_data[0];
                    REG_TONE_ENABLE:    cfg_reg.tone_enable    <= cfg_data[0];
                    default:            cfg_reg                <= cfg_reg;
                endcase
            end
        end
    end

    // Payload registers: hold on stall, load on transfer.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_addr_reg <= s_tdata[BYTE_BITS-1:0];
            in_data_reg <= s_tdata[2*BYTE_BITS-1:BYTE_BITS];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    mts_seq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cfg       (cfg_reg),
        .ram_rdata (ram_rdata),
        .ram_raddr (ram_raddr),
        .ram_wr    (ram_wr),
        .result    (result),
        .status    (status)
    );

    mts_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS-PTR_BITS-4){1'b0}},
                       out_data_reg.play_address,
                       out_data_reg.word_invalid,
                       out_data_reg.stop_flag,
                       out_data_reg.one_second,
                       out_data_reg.tone_out};

    `MTS_ASSERT(a_ready_when_empty, in_valid_reg || s_tready, "input stage empty but not ready")
    `MTS_ASSERT(a_fwd_after_write, !status.fwd_active || $past(ram_wr.en), "forward without write")
    `MTS_ASSERT_NEXT(a_stop_sticky, advance && result.stop_flag, out_data_reg.stop_flag && !(advance && !result.stop_flag), "stop flag cleared")
    `MTS_ASSERT_NEXT(a_pointer_hold, !status.tick_done, status.tick_done || $stable(ram_raddr), "play address moved without tick")

endmodule
